>>> sv/assert_macros.svh
// assertion macros included by buddy_block_allocator_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst, prop, msg)
`define BBA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> sv/bba_pkg.sv
// package of the buddy block allocator: constants, command codes, link store controls
// no dependencies
`timescale 1ns / 1ps
package bba_pkg;

  localparam int LEVELS_DEF      = 12;
  localparam int MIN_LEAF_LOG2   = 4;
  localparam int LEAF_LOG2_RESET = 4;

  localparam int CMD_W    = 2;
  localparam int BYTES_W  = 32;
  localparam int OFFSET_W = 11;
  localparam int LOG2_W   = 5;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic REG_LEAF_SIZE_LOG2 = 1'b0;

  typedef struct packed {
    logic next_we;
    logic prev_we;
  } bba_link_we_t;

endpackage

>>> sv/bba_if.sv
// request and response channel interfaces of the buddy block allocator
// depends on bba_pkg
`timescale 1ns / 1ps
interface bba_req_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::CMD_W-1:0]     cmd;
  logic [bba_pkg::BYTES_W-1:0]   request_bytes;
  logic [bba_pkg::OFFSET_W-1:0]  block_offset;
  modport source (output valid, cmd, request_bytes, block_offset, input ready);
  modport sink (input valid, cmd, request_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [bba_pkg::OFFSET_W-1:0]  granted_offset;
  modport source (output valid, ok, granted_offset, input ready);
  modport sink (input valid, ok, granted_offset, output ready);
endinterface

>>> sv/bba_link_store.sv
// free list next and prev link memories, one write port each, shared registered read
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_link_store #(
  parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
  input  logic                  clk,
  input  bba_pkg::bba_link_we_t we,
  input  logic [LEVELS-2:0]     raddr,
  input  logic [LEVELS-2:0]     next_waddr,
  input  logic [LEVELS-1:0]     next_wdata,
  input  logic [LEVELS-2:0]     prev_waddr,
  input  logic [LEVELS-1:0]     prev_wdata,
  output logic [LEVELS-1:0]     rnext,
  output logic [LEVELS-1:0]     rprev
);
  localparam int LEAVES = 1 << (LEVELS - 1);

  logic [LEVELS-1:0] next_mem [LEAVES];
  logic [LEVELS-1:0] prev_mem [LEAVES];

  always_ff @(posedge clk) begin
    if (we.next_we) next_mem[next_waddr] <= next_wdata;
    if (we.prev_we) prev_mem[prev_waddr] <= prev_wdata;
    rnext <= next_mem[raddr];
    rprev <= prev_mem[raddr];
  end
endmodule

>>> sv/buddy_block_allocator_core.sv
// Binary buddy allocator over 2^(LEVELS-1) leaves with per-level LIFO free lists.
// One command at a time runs under a sequencer over the split/used bit memory
// (2^LEVELS entries), the link memories and the list head registers. After reset
// a clearing pass over the bit memory runs before the first word is taken. Init
// clears the bit memory and then seeds the free lists level by level. Alloc rounds
// the size up, searches the levels for a free block, unlinks it and splits it down
// level by level. Free takes the same rounding and at each merge level searches
// the free list for the buddy when the buddy's bit is clear.
// Configuration writes are taken at any time.
// depends on bba_pkg, bba_if, bba_link_store, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module buddy_block_allocator_core #(
  parameter int LEVELS = bba_pkg::LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  bba_req_if.sink             req,
  bba_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int LW     = LEVELS - 1;
  localparam int NW     = LEVELS;
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int HIW    = $clog2(LEVELS);
  localparam int LEAVES = 1 << (LEVELS - 1);
  localparam int NODES  = 1 << LEVELS;
  localparam logic [NW-1:0] NIL = NW'(LEAVES);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CLEAR  = 15'b000000000000010,
    S_SIZE   = 15'b000000000000100,
    S_FIND   = 15'b000000000001000,
    S_UNL    = 15'b000000000010000,
    S_UNL2   = 15'b000000000100000,
    S_SPLIT  = 15'b000000001000000,
    S_PUSH   = 15'b000000010000000,
    S_PUSH2  = 15'b000000100000000,
    S_SEED   = 15'b000001000000000,
    S_MERGE  = 15'b000010000000000,
    S_BUDDY  = 15'b000100000000000,
    S_SEARCH = 15'b001000000000000,
    S_SWAIT  = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_t;

  function automatic logic [LVW-1:0] sh_of(input logic [LVW-1:0] l);
    return LVW'(LEVELS - 1) - l;
  endfunction

  function automatic logic [NW-1:0] tidx(input logic [LW-1:0] n, input logic [LVW-1:0] l);
    return (NW'(n) >> sh_of(l)) + (NW'(1) << l);
  endfunction

  state_t                      state;
  logic [bba_pkg::CMD_W-1:0]   op;
  logic [bba_pkg::LOG2_W-1:0]  leaf_log2;
  logic [bba_pkg::LOG2_W-1:0]  active_log2;
  logic [NW-1:0]               heads [LEVELS];
  logic [32:0]                 n_q;
  logic [LW-1:0]               off_q;
  logic                        offovr;
  logic [NW-1:0]               pw;
  logic [LVW-1:0]              kk;
  logic [LVW-1:0]              want;
  logic [LVW-1:0]              lvl;
  logic [LVW-1:0]              pl;
  logic [LVW-1:0]              rl;
  logic                        seeding;
  logic [LVW-1:0]              cl;
  logic [LW-1:0]               ci;
  logic [NW-1:0]               left;
  logic [NW-1:0]               pos;
  logic [LW-1:0]               node;
  logic [LW-1:0]               idx;
  logic [LW-1:0]               un;
  logic [LW-1:0]               pn;
  logic [NW-1:0]               ph;
  logic [NW-1:0]               cur;
  logic [NW-1:0]               steps;
  logic                        res_ok;
  logic [LW-1:0]               res_off;
  logic                        out_valid;
  logic                        out_ok;
  logic [bba_pkg::OFFSET_W-1:0] out_off;

  logic                        tree_mem [NODES];
  logic                        t_we;
  logic [NW-1:0]               t_addr;
  logic                        t_wd;
  logic [NW-1:0]               t_raddr;
  logic                        t_rbit;

  bba_pkg::bba_link_we_t       lk_we;
  logic [LW-1:0]               l_raddr;
  logic [LW-1:0]               nwa;
  logic [NW-1:0]               nwd;
  logic [LW-1:0]               pwa;
  logic [NW-1:0]               pwd;
  logic [NW-1:0]               l_rnext;
  logic [NW-1:0]               l_rprev;

  logic [LVW-1:0]              hsel;
  logic [NW-1:0]               head_rd;
  logic [NW-1:0]               rsv;
  logic [32:0]                 n_calc;
  logic [bba_pkg::LOG2_W-1:0]  lg_init;
  logic                        accept;
  logic                        search_end;
  logic                        search_hit;

  bba_link_store #(.LEVELS(LEVELS)) u_links (
    .clk        (clk),
    .we         (lk_we),
    .raddr      (l_raddr),
    .next_waddr (nwa),
    .next_wdata (nwd),
    .prev_waddr (pwa),
    .prev_wdata (pwd),
    .rnext      (l_rnext),
    .rprev      (l_rprev)
  );

  always_ff @(posedge clk) begin
    if (t_we) tree_mem[t_addr] <= t_wd;
    t_rbit <= tree_mem[t_raddr];
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(leaf_log2);

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_log2 <= bba_pkg::LOG2_W'(bba_pkg::LEAF_LOG2_RESET);
    end else if (psel && penable && pwrite && paddr[2] == bba_pkg::REG_LEAF_SIZE_LOG2) begin
      leaf_log2 <= pwdata[bba_pkg::LOG2_W-1:0];
    end
  end

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.ok     = out_ok;
  assign rsp.granted_offset = out_off;

  assign hsel    = (state == S_PUSH) ? pl : lvl;
  assign head_rd = heads[hsel[HIW-1:0]];
  assign rsv     = NW'(1) << rl;
  assign n_calc  = ({1'b0, req.request_bytes} + ((33'd1 << active_log2) - 33'd1)) >> active_log2;
  assign lg_init = (leaf_log2 < bba_pkg::LOG2_W'(bba_pkg::MIN_LEAF_LOG2)) ?
                   bba_pkg::LOG2_W'(bba_pkg::MIN_LEAF_LOG2) : leaf_log2;
  assign search_end = (cur == NIL) || (steps == NW'(LEAVES));
  assign search_hit = (cur[LW-1:0] >> sh_of(lvl)) == (idx ^ LW'(1));

  always_comb begin
    t_we    = 1'b0;
    t_addr  = '0;
    t_wd    = 1'b0;
    t_raddr = '0;
    lk_we   = '0;
    l_raddr = '0;
    nwa     = '0;
    nwd     = '0;
    pwa     = '0;
    pwd     = '0;
    case (state)
      S_CLEAR: begin
        t_we   = 1'b1;
        t_addr = NW'(ci) | (NW'(1) << cl);
        t_wd   = seeding && ((NW'(ci) << sh_of(cl)) < rsv);
      end
      S_FIND: begin
        if (head_rd != NIL) begin
          t_we   = 1'b1;
          t_addr = tidx(head_rd[LW-1:0], lvl);
          t_wd   = 1'b1;
        end
      end
      S_UNL: l_raddr = un;
      S_UNL2: begin
        if (l_rprev != NIL) begin
          lk_we.next_we = 1'b1;
          nwa = l_rprev[LW-1:0];
          nwd = l_rnext;
        end
        if (l_rnext != NIL) begin
          lk_we.prev_we = 1'b1;
          pwa = l_rnext[LW-1:0];
          pwd = l_rprev;
        end
        if (op == bba_pkg::CMD_FREE) begin
          t_we   = 1'b1;
          t_addr = NW'(idx ^ LW'(1)) + (NW'(1) << lvl);
          t_wd   = 1'b0;
        end
      end
      S_SPLIT: begin
        if (lvl <= want) begin
          t_we   = 1'b1;
          t_addr = tidx(node, lvl);
          t_wd   = 1'b1;
        end
      end
      S_PUSH: begin
        lk_we.next_we = 1'b1;
        lk_we.prev_we = 1'b1;
        nwa = pn;
        nwd = head_rd;
        pwa = pn;
        pwd = NIL;
      end
      S_PUSH2: begin
        if (ph != NIL) begin
          lk_we.prev_we = 1'b1;
          pwa = ph[LW-1:0];
          pwd = NW'(pn);
        end
      end
      S_MERGE: begin
        t_we    = 1'b1;
        t_addr  = NW'(idx) + (NW'(1) << lvl);
        t_wd    = 1'b0;
        t_raddr = NW'(idx ^ LW'(1)) + (NW'(1) << lvl);
      end
      S_SEARCH: l_raddr = cur[LW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      op          <= bba_pkg::CMD_INIT;
      active_log2 <= bba_pkg::LOG2_W'(bba_pkg::LEAF_LOG2_RESET);
      seeding     <= 1'b0;
      cl          <= '0;
      ci          <= '0;
      rl          <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < LEVELS; i++) heads[i] <= NIL;
    end else begin
      if (rsp.ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op      <= req.cmd;
            n_q     <= n_calc;
            off_q   <= LW'(req.block_offset);
            offovr  <= 32'(req.block_offset) >= 32'(LEAVES);
            pw      <= NW'(1);
            kk      <= '0;
            res_ok  <= 1'b0;
            res_off <= '0;
            case (req.cmd)
              bba_pkg::CMD_INIT: begin
                active_log2 <= lg_init;
                for (int i = 0; i < LEVELS; i++) heads[i] <= NIL;
                if (32'(LEVELS - 1) >= 32'(lg_init) + 32'd2) begin
                  rl <= LVW'(32'(LEVELS) - 32'd3 - 32'(lg_init));
                end else begin
                  rl <= '0;
                end
                seeding <= 1'b1;
                cl      <= '0;
                ci      <= '0;
                state   <= S_CLEAR;
              end
              bba_pkg::CMD_ALLOC, bba_pkg::CMD_FREE: state <= S_SIZE;
              default: state <= S_FIN;
            endcase
          end
        end
        S_CLEAR: begin
          if (NW'(ci) == (NW'(1) << cl) - NW'(1)) begin
            ci <= '0;
            if (cl == LVW'(LEVELS - 1)) begin
              if (seeding) begin
                left  <= NW'(LEAVES) - rsv;
                pos   <= rsv;
                lvl   <= LVW'(LEVELS - 1);
                state <= S_SEED;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              cl <= cl + LVW'(1);
            end
          end else begin
            ci <= ci + LW'(1);
          end
        end
        S_SEED: begin
          if (left == '0) begin
            res_ok <= 1'b1;
            state  <= S_FIN;
          end else begin
            if (left[0]) begin
              pn    <= pos[LW-1:0];
              pl    <= lvl;
              pos   <= pos + (NW'(1) << sh_of(lvl));
              state <= S_PUSH;
            end
            left <= left >> 1;
            lvl  <= lvl - LVW'(1);
          end
        end
        S_SIZE: begin
          if (n_q > 33'(LEAVES) || (op == bba_pkg::CMD_FREE && offovr)) begin
            state <= S_FIN;
          end else if (kk < LVW'(LEVELS - 1) && 33'(pw) < n_q) begin
            kk <= kk + LVW'(1);
            pw <= pw << 1;
          end else begin
            want <= LVW'(LEVELS - 1) - kk;
            lvl  <= LVW'(LEVELS - 1) - kk;
            idx  <= off_q >> kk;
            state <= (op == bba_pkg::CMD_ALLOC) ? S_FIND : S_MERGE;
          end
        end
        S_FIND: begin
          if (head_rd != NIL) begin
            node  <= head_rd[LW-1:0];
            un    <= head_rd[LW-1:0];
            state <= S_UNL;
          end else if (lvl == '0) begin
            state <= S_FIN;
          end else begin
            lvl <= lvl - LVW'(1);
          end
        end
        S_UNL: state <= S_UNL2;
        S_UNL2: begin
          if (l_rprev == NIL) heads[lvl[HIW-1:0]] <= l_rnext;
          if (op == bba_pkg::CMD_ALLOC) begin
            lvl   <= lvl + LVW'(1);
            state <= S_SPLIT;
          end else begin
            lvl   <= lvl - LVW'(1);
            idx   <= idx >> 1;
            state <= S_MERGE;
          end
        end
        S_SPLIT: begin
          if (lvl > want) begin
            res_ok  <= 1'b1;
            res_off <= node;
            state   <= S_FIN;
          end else begin
            pn    <= node + (LW'(1) << sh_of(lvl));
            pl    <= lvl;
            lvl   <= lvl + LVW'(1);
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          ph <= head_rd;
          heads[pl[HIW-1:0]] <= NW'(pn);
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          case (op)
            bba_pkg::CMD_INIT:  state <= S_SEED;
            bba_pkg::CMD_ALLOC: state <= S_SPLIT;
            default: begin
              res_ok <= 1'b1;
              state  <= S_FIN;
            end
          endcase
        end
        S_MERGE: begin
          if (lvl == '0) begin
            pn    <= idx << sh_of(lvl);
            pl    <= lvl;
            state <= S_PUSH;
          end else begin
            state <= S_BUDDY;
          end
        end
        S_BUDDY: begin
          if (t_rbit) begin
            pn    <= idx << sh_of(lvl);
            pl    <= lvl;
            state <= S_PUSH;
          end else begin
            cur   <= head_rd;
            steps <= '0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (search_end) begin
            pn    <= idx << sh_of(lvl);
            pl    <= lvl;
            state <= S_PUSH;
          end else if (search_hit) begin
            un    <= cur[LW-1:0];
            state <= S_UNL;
          end else begin
            state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          cur   <= l_rnext;
          steps <= steps + NW'(1);
          state <= S_SEARCH;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_ok    <= res_ok;
            out_off   <= res_ok ? bba_pkg::OFFSET_W'(res_off) : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT(a_one_at_a_time, clk, rst, accept |=> !req.ready, "word taken while busy")
  `BBA_ASSERT(a_fail_no_offset, clk, rst, (rsp.valid && !rsp.ok) |-> (rsp.granted_offset == '0), "offset on failure")
  `BBA_ASSERT(a_steps_bound, clk, rst, (state == S_SEARCH) |-> (steps <= NW'(LEAVES)), "list search overran")
  `BBA_ASSERT_NR(a_reset_idle_out, clk, rst |=> !rsp.valid, "result after reset")
endmodule
